// ----- hw/rtl/http_response_header_parser_assert.svh -----
// Assertion macros shared by the HTTP response header parser modules.
// Depends on a clock named clk and a synchronous reset named rst in the using scope.
`ifndef HTTP_RESPONSE_HEADER_PARSER_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HRP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrp assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HRP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrp assertion failed");

`endif

// ----- hw/rtl/hrp_pkg.sv -----
// Shared types and constants for the HTTP response header parser.
// No dependencies; used by front, queue, back and top level.
`timescale 1ns / 1ps

package hrp_pkg;

  // Result status codes
  localparam logic [1:0] ST_BODY  = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_LOST  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Word matching
  localparam int TOKEN_LEN  = 8;
  localparam int KEY_LEN    = 15;
  localparam int KEY_HIT_W  = 16;
  localparam int CHAR_POS_W = 5;

  localparam logic [7:0] VERSION_TOK [TOKEN_LEN] = '{
    "H", "T", "T", "P", "/", "1", ".", "1"
  };
  localparam logic [7:0] KEY_TOK [KEY_LEN] = '{
    "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h", ":"
  };

  // Decoupling queue
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCOUNT_W = QPTR_W + 1;

  // One classified byte as handed from the front to the back
  typedef struct packed {
    logic                 closed;
    logic                 is_cr;
    logic                 is_lf;
    logic                 is_space;
    logic                 is_ws;
    logic                 is_plus;
    logic                 is_minus;
    logic                 is_digit;
    logic [3:0]           digit;
    logic [7:0]           data;
    logic [TOKEN_LEN-1:0] ver_hit;
    logic [KEY_HIT_W-1:0] key_hit;
  } item_t;

endpackage

// ----- hw/rtl/hrp_front.sv -----
// Front end: accepts response bytes and classifies them for the back end.
// Depends on hrp_pkg (item_t, character constants, match tables).
`timescale 1ns / 1ps

module hrp_front (
  input  logic          byte_valid,
  output logic          byte_stall,
  input  logic [7:0]    rx_byte,
  input  logic          closed,
  input  logic          q_full,
  output logic          push,
  output hrp_pkg::item_t push_item
);

  assign byte_stall = q_full;
  assign push       = byte_valid && !q_full;

  always_comb begin
    push_item          = '0;
    push_item.closed   = closed;
    push_item.data     = rx_byte;
    push_item.is_cr    = (rx_byte == hrp_pkg::CH_CR);
    push_item.is_lf    = (rx_byte == hrp_pkg::CH_LF);
    push_item.is_space = (rx_byte == hrp_pkg::CH_SP);
    push_item.is_ws    = (rx_byte == hrp_pkg::CH_TAB) || (rx_byte == hrp_pkg::CH_VT) ||
                         (rx_byte == hrp_pkg::CH_FF);
    push_item.is_plus  = (rx_byte == hrp_pkg::CH_PLUS);
    push_item.is_minus = (rx_byte == hrp_pkg::CH_MINUS);
    push_item.is_digit = (rx_byte >= hrp_pkg::CH_ZERO) && (rx_byte <= hrp_pkg::CH_NINE);
    push_item.digit    = rx_byte[3:0];
    // match the byte against every position of both words at once
    for (int i = 0; i < hrp_pkg::TOKEN_LEN; i++) begin
      push_item.ver_hit[i] = (rx_byte == hrp_pkg::VERSION_TOK[i]);
    end
    for (int i = 0; i < hrp_pkg::KEY_LEN; i++) begin
      push_item.key_hit[i] = (rx_byte == hrp_pkg::KEY_TOK[i]);
    end
  end

endmodule

// ----- hw/rtl/hrp_queue.sv -----
// Short FIFO of classified bytes between front and back end.
// Depends on hrp_pkg (item_t, queue depth constants).
`timescale 1ns / 1ps

module hrp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hrp_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output hrp_pkg::item_t head
);

  hrp_pkg::item_t               mem [hrp_pkg::QDEPTH];
  logic [hrp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [hrp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [hrp_pkg::QCOUNT_W-1:0] count;

  assign full  = (count == hrp_pkg::QCOUNT_W'(hrp_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/hrp_back.sv -----
// Back end: header state machine, length accumulator, body framing, result register.
// Depends on hrp_pkg and http_response_header_parser_assert.svh.
`timescale 1ns / 1ps
`include "http_response_header_parser_assert.svh"

module hrp_back #(
  parameter int LEN_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  hrp_pkg::item_t head,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_stall,
  output logic [1:0]     status,
  output logic [7:0]     body_byte,
  output logic           final_res,
  output logic [30:0]    length_out
);

  // length values never exceed min(2^(LEN_WIDTH-1)-1, 2^31-1): all ones of AW bits
  localparam int AW = (LEN_WIDTH - 1 > 31) ? 31 : LEN_WIDTH - 1;
  localparam int CW = hrp_pkg::CHAR_POS_W;

  logic          in_body, in_body_next;
  logic          cr_pending, cr_pending_next;
  logic          lf_before, lf_before_next;
  logic [1:0]    word_number, word_number_next;
  logic [CW-1:0] char_pos, char_pos_next;
  logic          status_token_ok, status_token_ok_next;
  logic          length_key_ok, length_key_ok_next;
  logic          value_expected, value_expected_next;
  logic          length_known, length_known_next;
  logic          value_negative, value_negative_next;
  logic          digits_ended, digits_ended_next;
  logic          value_started, value_started_next;
  logic [AW-1:0] value_accum, value_accum_next;
  logic [AW-1:0] length_value, length_value_next;
  logic [AW-1:0] body_count, body_count_next;

  logic          emit, terminal, emit_final;
  logic [1:0]    emit_status;
  logic [7:0]    emit_byte;
  logic [AW:0]   count_inc;
  logic [AW+3:0] acc_wide;
  logic [1:0]    word_inc;

  assign pop       = !q_empty && (!res_valid || !res_stall);
  assign count_inc = {1'b0, body_count} + 1'b1;
  assign acc_wide  = ({4'b0, value_accum} << 3) + ({4'b0, value_accum} << 1) +
                     (AW + 4)'(head.digit);
  assign word_inc  = (word_number == 2'd3) ? 2'd3 : word_number + 2'd1;

  always_comb begin
    in_body_next         = in_body;
    cr_pending_next      = cr_pending;
    lf_before_next       = lf_before;
    word_number_next     = word_number;
    char_pos_next        = char_pos;
    status_token_ok_next = status_token_ok;
    length_key_ok_next   = length_key_ok;
    value_expected_next  = value_expected;
    length_known_next    = length_known;
    value_negative_next  = value_negative;
    digits_ended_next    = digits_ended;
    value_started_next   = value_started;
    value_accum_next     = value_accum;
    length_value_next    = length_value;
    body_count_next      = body_count;
    emit                 = 1'b0;
    terminal             = 1'b0;
    emit_final           = 1'b0;
    emit_status          = hrp_pkg::ST_BODY;
    emit_byte            = '0;

    if (head.closed) begin
      emit        = 1'b1;
      terminal    = 1'b1;
      emit_final  = 1'b1;
      emit_status = hrp_pkg::ST_LOST;
    end else if (in_body) begin
      body_count_next = count_inc[AW-1:0];
      emit            = 1'b1;
      emit_byte       = head.data;
      if (count_inc >= {1'b0, length_value}) begin
        terminal   = 1'b1;
        emit_final = 1'b1;
      end
    end else if (cr_pending != head.is_lf) begin
      emit        = 1'b1;
      terminal    = 1'b1;
      emit_final  = 1'b1;
      emit_status = hrp_pkg::ST_BAD;
    end else if (head.is_cr) begin
      cr_pending_next = 1'b1;
    end else begin
      cr_pending_next = 1'b0;
      if (head.is_lf && lf_before) begin
        // blank line: header done
        if (!length_known) begin
          emit        = 1'b1;
          terminal    = 1'b1;
          emit_final  = 1'b1;
          emit_status = hrp_pkg::ST_BAD;
        end else if (length_value == '0) begin
          emit        = 1'b1;
          terminal    = 1'b1;
          emit_final  = 1'b1;
          emit_status = hrp_pkg::ST_EMPTY;
        end else begin
          in_body_next    = 1'b1;
          body_count_next = '0;
        end
      end else begin
        lf_before_next = head.is_lf;
        if (head.is_lf || head.is_space) begin
          word_number_next = word_inc;
          if (value_expected) begin
            value_expected_next = 1'b0;
            if (value_negative && value_accum != '0) begin
              length_known_next = 1'b0;
              length_value_next = '0;
            end else begin
              length_known_next = 1'b1;
              length_value_next = value_accum;
            end
          end else if (word_inc == 2'd1 &&
                       !(status_token_ok && char_pos == CW'(hrp_pkg::TOKEN_LEN))) begin
            emit        = 1'b1;
            terminal    = 1'b1;
            emit_final  = 1'b1;
            emit_status = hrp_pkg::ST_BAD;
          end else if (length_key_ok && char_pos == CW'(hrp_pkg::KEY_LEN)) begin
            value_expected_next = 1'b1;
          end
          char_pos_next        = '0;
          status_token_ok_next = 1'b1;
          length_key_ok_next   = 1'b1;
          value_negative_next  = 1'b0;
          digits_ended_next    = 1'b0;
          value_started_next   = 1'b0;
          value_accum_next     = '0;
        end else begin
          if (char_pos >= CW'(hrp_pkg::TOKEN_LEN) || !head.ver_hit[char_pos[2:0]]) begin
            status_token_ok_next = 1'b0;
          end
          if (char_pos >= CW'(hrp_pkg::KEY_LEN) || !head.key_hit[char_pos[3:0]]) begin
            length_key_ok_next = 1'b0;
          end
          if (char_pos != {CW{1'b1}}) begin
            char_pos_next = char_pos + 1'b1;
          end
          if (value_expected && !digits_ended) begin
            if (!value_started && head.is_ws) begin
              value_started_next = 1'b0;
            end else if (!value_started && (head.is_plus || head.is_minus)) begin
              value_started_next  = 1'b1;
              value_negative_next = head.is_minus;
            end else begin
              value_started_next = 1'b1;
              if (head.is_digit) begin
                // saturate at all ones of AW bits
                value_accum_next = (acc_wide[AW+3:AW] != '0) ? {AW{1'b1}} : acc_wide[AW-1:0];
              end else begin
                digits_ended_next = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && terminal)) begin
      in_body         <= 1'b0;
      cr_pending      <= 1'b0;
      lf_before       <= 1'b0;
      word_number     <= '0;
      char_pos        <= '0;
      status_token_ok <= 1'b1;
      length_key_ok   <= 1'b1;
      value_expected  <= 1'b0;
      length_known    <= 1'b0;
      value_negative  <= 1'b0;
      digits_ended    <= 1'b0;
      value_started   <= 1'b0;
      value_accum     <= '0;
      length_value    <= '0;
      body_count      <= '0;
    end else if (pop) begin
      in_body         <= in_body_next;
      cr_pending      <= cr_pending_next;
      lf_before       <= lf_before_next;
      word_number     <= word_number_next;
      char_pos        <= char_pos_next;
      status_token_ok <= status_token_ok_next;
      length_key_ok   <= length_key_ok_next;
      value_expected  <= value_expected_next;
      length_known    <= length_known_next;
      value_negative  <= value_negative_next;
      digits_ended    <= digits_ended_next;
      value_started   <= value_started_next;
      value_accum     <= value_accum_next;
      length_value    <= length_value_next;
      body_count      <= body_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      status     <= emit_status;
      body_byte  <= emit_byte;
      final_res  <= emit_final;
      length_out <= 31'(length_value);
    end
  end

  `HRP_ASSERT_IMP(a_body_len_known, in_body, length_known && length_value != '0)
  `HRP_ASSERT_IMP(a_body_count_below, in_body, body_count < length_value)
  `HRP_ASSERT_IMP(a_term_final, res_valid && status != hrp_pkg::ST_BODY, final_res)
  `HRP_ASSERT_NXT(a_term_clears, pop && terminal, !in_body && word_number == 2'd0)

endmodule

// ----- hw/rtl/http_response_header_parser.sv -----
// HTTP response header parser: front classifier, 4-entry queue, back state machine.
// Each accepted byte is queued, then popped by the back end, which registers its result.
// One byte per cycle unless the queue is full; a queued byte retires each cycle res is free.
// Reset: synchronous active-high rst empties the queue, drops any pending result and
// returns the parser to the header phase. Depends on hrp_pkg, hrp_front, hrp_queue, hrp_back.
`timescale 1ns / 1ps

module http_response_header_parser #(
  parameter int LEN_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // byte channel: one transaction per received byte or close mark
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  input  logic        closed,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [7:0]  body_byte,
  output logic        final_res,
  output logic [30:0] length_out
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  hrp_pkg::item_t push_item;
  hrp_pkg::item_t head;

  // Classify each byte on acceptance; stall only when the queue is full.
  hrp_front u_front (
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .rx_byte    (rx_byte),
    .closed     (closed),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Hold classified transactions so the byte side keeps flowing while results wait.
  hrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  // Advance header/body state one transaction per cycle while res is free; register any result.
  hrp_back #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (status),
    .body_byte  (body_byte),
    .final_res  (final_res),
    .length_out (length_out)
  );

endmodule
